FILE: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = 3;
  localparam int RANK_W    = 3;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 4;

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] FC_RESET = CFG_W'(4);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // victim / target decision for one reference
  typedef struct packed {
    logic  hit;
    logic  evict;
    slot_t slot;
  } pick_t;

endpackage

FILE: rtl/lrupr_if.sv
`timescale 1ns / 1ps

interface lrupr_req_if;
  logic                 valid;
  logic                 ready;
  lrupr_pkg::page_t     page_number;
  logic                 restart;

  modport source (output valid, output page_number, output restart, input ready);
  modport sink   (input valid, input page_number, input restart, output ready);
endinterface

interface lrupr_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted;
  lrupr_pkg::page_t     evicted_page;
  lrupr_pkg::slot_t     frame_slot;
  lrupr_pkg::cnt_t      fault_count;
  lrupr_pkg::cnt_t      hit_count;

  modport source (output valid, output hit, output evicted, output evicted_page,
                  output frame_slot, output fault_count, output hit_count,
                  input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_page,
                  input frame_slot, input fault_count, input hit_count,
                  output ready);
endinterface

FILE: rtl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
// A reference accepted is registered in the input stage, resolved there and
// written to the output stage, from which its result word is shown.
// Throughput: one reference per cycle while the result word is not held back,
// set by the combinational tag compare and recency-rank update over all frames.
// Reset: frames invalid, ranks and counters zero, frame_count 4; no sweep.

module lru_page_replacement_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_wdata_i,
  lrupr_req_if.sink                    req_i,
  lrupr_rsp_if.source                  rsp_o
);

  localparam int F = lrupr_pkg::FRAMES;

  // input stage
  logic             in_vq, in_vd;
  lrupr_pkg::page_t in_page_q;
  logic             in_restart_q;

  // frame state
  logic [lrupr_pkg::CFG_W-1:0] fc_q;
  lrupr_pkg::page_t pages_q [F];
  logic [F-1:0]     valid_q, valid_d;
  lrupr_pkg::rank_t ranks_q [F];
  lrupr_pkg::rank_t ranks_d [F];
  lrupr_pkg::cnt_t  faults_q, faults_d;
  lrupr_pkg::cnt_t  hits_q, hits_d;

  // output stage
  logic             out_vq, out_vd;
  logic             o_hit_q, o_evict_q;
  lrupr_pkg::page_t o_epage_q;
  lrupr_pkg::slot_t o_slot_q;
  lrupr_pkg::cnt_t  o_faults_q, o_hits_q;

  logic             proc;
  logic             req_take;
  logic [F-1:0]     in_use;
  logic [lrupr_pkg::CFG_W-1:0] n_eff;
  logic [F-1:0]     valid_eff;
  lrupr_pkg::rank_t ranks_eff [F];
  lrupr_pkg::cnt_t  faults_eff, hits_eff;
  lrupr_pkg::pick_t pick;
  lrupr_pkg::rank_t tgt_rank;
  logic             was_valid;

  assign proc     = in_vq && (!out_vq || rsp_o.ready);
  assign req_i.ready = !in_vq || proc;
  assign req_take = req_i.valid && req_i.ready;
  assign in_vd    = req_take || (in_vq && !proc);
  assign out_vd   = proc || (out_vq && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      in_vq  <= in_vd;
      out_vq <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_page_q    <= req_i.page_number;
      in_restart_q <= req_i.restart;
    end
  end

  // clamp frame count to 1..FRAMES
  always_comb begin
    if (fc_q == '0) begin
      n_eff = lrupr_pkg::CFG_W'(1);
    end else if (fc_q > lrupr_pkg::CFG_W'(F)) begin
      n_eff = lrupr_pkg::CFG_W'(F);
    end else begin
      n_eff = fc_q;
    end
    for (int i = 0; i < F; i++) begin
      in_use[i] = lrupr_pkg::CFG_W'(i) < n_eff;
    end
  end

  // restart wipes state before the reference is looked up
  always_comb begin
    valid_eff  = in_restart_q ? '0 : valid_q;
    faults_eff = in_restart_q ? '0 : faults_q;
    hits_eff   = in_restart_q ? '0 : hits_q;
    for (int i = 0; i < F; i++) begin
      ranks_eff[i] = in_restart_q ? '0 : ranks_q[i];
    end
  end

  lrupr_pick u_pick (
    .page_i   (in_page_q),
    .pages_i  (pages_q),
    .valid_i  (valid_eff),
    .ranks_i  (ranks_eff),
    .in_use_i (in_use),
    .pick_o   (pick)
  );

  // move target to rank 0; frames more recent than it age by one (every valid frame on a free-slot fill)
  always_comb begin
    tgt_rank  = ranks_eff[pick.slot];
    was_valid = pick.hit || pick.evict;
    valid_d   = valid_eff;
    for (int i = 0; i < F; i++) begin
      ranks_d[i] = ranks_eff[i];
      if ((lrupr_pkg::SLOT_W'(i) != pick.slot) && valid_eff[i] &&
          (!was_valid || (ranks_eff[i] < tgt_rank))) begin
        ranks_d[i] = ranks_eff[i] + lrupr_pkg::RANK_W'(1);
      end
    end
    ranks_d[pick.slot] = '0;
    valid_d[pick.slot] = 1'b1;
  end

  always_comb begin
    faults_d = faults_eff;
    hits_d   = hits_eff;
    if (pick.hit) begin
      if (hits_eff != lrupr_pkg::CNT_MAX) hits_d = hits_eff + lrupr_pkg::CNT_W'(1);
    end else begin
      if (faults_eff != lrupr_pkg::CNT_MAX) faults_d = faults_eff + lrupr_pkg::CNT_W'(1);
    end
  end

  // a frame_count write invalidates every frame and takes priority
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q     <= lrupr_pkg::FC_RESET;
      valid_q  <= '0;
      faults_q <= '0;
      hits_q   <= '0;
      for (int i = 0; i < F; i++) begin
        ranks_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      fc_q    <= cfg_wdata_i;
      valid_q <= '0;
      for (int i = 0; i < F; i++) begin
        ranks_q[i] <= '0;
      end
    end else if (proc) begin
      valid_q  <= valid_d;
      faults_q <= faults_d;
      hits_q   <= hits_d;
      for (int i = 0; i < F; i++) begin
        ranks_q[i] <= ranks_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && !cfg_we_i && !pick.hit) begin
      pages_q[pick.slot] <= in_page_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      o_hit_q    <= pick.hit;
      o_evict_q  <= pick.evict;
      o_epage_q  <= pick.evict ? pages_q[pick.slot] : '0;
      o_slot_q   <= pick.slot;
      o_faults_q <= faults_d;
      o_hits_q   <= hits_d;
    end
  end

  assign rsp_o.valid        = out_vq;
  assign rsp_o.hit          = o_hit_q;
  assign rsp_o.evicted      = o_evict_q;
  assign rsp_o.evicted_page = o_epage_q;
  assign rsp_o.frame_slot   = o_slot_q;
  assign rsp_o.fault_count  = o_faults_q;
  assign rsp_o.hit_count    = o_hits_q;

`ifndef SYNTHESIS
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (valid_q == '0))
    else $error("frame_count write did not invalidate frames");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q & ~in_use) == 0)
    else $error("valid frame outside the frames in use");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && pick.evict) |-> ($countones(valid_eff & in_use) == int'(n_eff)))
    else $error("eviction while a free frame was left");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("result word flags both hit and eviction");

  a_epage_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.evicted) |-> (rsp_o.evicted_page == '0))
    else $error("evicted_page nonzero without eviction");
`endif

endmodule

FILE: rtl/lrupr_pick.sv
`timescale 1ns / 1ps

// Tag compare over all frames, then hit slot, lowest free slot or LRU victim.
module lrupr_pick (
  input  lrupr_pkg::page_t                     page_i,
  input  lrupr_pkg::page_t                     pages_i [lrupr_pkg::FRAMES],
  input  logic             [lrupr_pkg::FRAMES-1:0] valid_i,
  input  lrupr_pkg::rank_t                     ranks_i [lrupr_pkg::FRAMES],
  input  logic             [lrupr_pkg::FRAMES-1:0] in_use_i,
  output lrupr_pkg::pick_t                     pick_o
);

  logic [lrupr_pkg::FRAMES-1:0] match;
  logic             hit_found;
  logic             free_found;
  lrupr_pkg::slot_t hit_slot;
  lrupr_pkg::slot_t free_slot;
  lrupr_pkg::slot_t lru_slot;
  lrupr_pkg::rank_t best;

  always_comb begin
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      match[i] = in_use_i[i] && valid_i[i] && (pages_i[i] == page_i);
    end
  end

  // downward scan so the lowest index wins
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_slot   = '0;
    free_slot  = '0;
    for (int i = lrupr_pkg::FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_found = 1'b1;
        hit_slot  = lrupr_pkg::SLOT_W'(i);
      end
      if (in_use_i[i] && !valid_i[i]) begin
        free_found = 1'b1;
        free_slot  = lrupr_pkg::SLOT_W'(i);
      end
    end
  end

  // oldest frame has the largest rank; strict compare keeps the lowest index
  always_comb begin
    best     = '0;
    lru_slot = '0;
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      if (in_use_i[i] && (ranks_i[i] > best)) begin
        best     = ranks_i[i];
        lru_slot = lrupr_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    pick_o.hit   = hit_found;
    pick_o.evict = !hit_found && !free_found;
    if (hit_found) begin
      pick_o.slot = hit_slot;
    end else if (free_found) begin
      pick_o.slot = free_slot;
    end else begin
      pick_o.slot = lru_slot;
    end
  end

endmodule
